[src/ffa_pkg.sv]
`timescale 1ns / 1ps
package ffa_pkg;
	localparam int HEAP_BYTES   = 65536;
	localparam int MAX_BLOCKS   = 256;
	localparam int HEADER_BYTES = 24;
	localparam int ALIGN_BYTES  = 16;

	localparam int SLOT_W = 8;
	localparam int LINK_W = 9;
	localparam int START_W = 16;
	localparam int SIZE_W  = 17;
	localparam int ALIGNED_W = 18;

	localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(MAX_BLOCKS);

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_FREE    = 2'd1;
	localparam logic [1:0] OP_REALLOC = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED = 3'd2;
	localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
	localparam logic [2:0] ST_TABLE_FULL = 3'd4;

	typedef struct packed {
		logic [LINK_W-1:0]  next;
		logic               free;
		logic [SIZE_W-1:0]  size;
		logic [START_W-1:0] start;
	} blk_t;

	localparam int BLK_W = $bits(blk_t);

	typedef struct packed {
		logic [15:0] block_address;
		logic [16:0] request_size;
		logic [1:0]  opcode;
	} req_t;

	typedef struct packed {
		logic [16:0] old_size;
		logic        moved;
		logic [15:0] result_address;
		logic [2:0]  status;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_ALLOC,
		S_TAKE,
		S_TAKE_W,
		S_SPLIT,
		S_SPLIT2,
		S_GROW,
		S_GROW2,
		S_SHRINK,
		S_MG_LD,
		S_MG_LDW,
		S_MG_NX,
		S_MG_EV,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		TK_SPLIT,
		TK_GROW,
		TK_SHRINK
	} take_ctx_t;
endpackage

[src/ffa_ram.sv]
`timescale 1ns / 1ps
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/ffa_ctrl.sv]
`timescale 1ns / 1ps
module ffa_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  ffa_pkg::req_t               req,
	output logic                        res_valid,
	input  logic                        res_ready,
	output ffa_pkg::res_t               res,
	input  logic [16:0]                 heap_limit,
	output logic                        blk_we,
	output logic [ffa_pkg::SLOT_W-1:0]  blk_waddr,
	output ffa_pkg::blk_t               blk_wdata,
	output logic [ffa_pkg::SLOT_W-1:0]  blk_raddr,
	input  ffa_pkg::blk_t               blk_rdata,
	output logic                        sp_we,
	output logic [ffa_pkg::SLOT_W-1:0]  sp_waddr,
	output logic [ffa_pkg::SLOT_W-1:0]  sp_wdata,
	output logic [ffa_pkg::SLOT_W-1:0]  sp_raddr,
	input  logic [ffa_pkg::SLOT_W-1:0]  sp_rdata
);
	import ffa_pkg::*;

	state_t state_q, state_d;
	logic [LINK_W-1:0] head_q, head_d, tail_q, tail_d;
	logic [SIZE_W-1:0] brk_q, brk_d;
	logic [LINK_W-1:0] fresh_q, fresh_d, rec_q, rec_d;

	logic [1:0]           op_q, op_d;
	logic [15:0]          addr_q, addr_d;
	logic [ALIGNED_W-1:0] al_q, al_d;
	logic [LINK_W-1:0]    cur_q, cur_d;
	blk_t                 cur_rec_q, cur_rec_d;
	logic [SLOT_W-1:0]    s_slot_q, s_slot_d;
	blk_t                 s_rec_q, s_rec_d;
	logic [SLOT_W-1:0]    n_q, n_d;
	take_ctx_t            ctx_q, ctx_d;
	logic [SLOT_W-1:0]    base_slot_q, base_slot_d;
	blk_t                 base_rec_q, base_rec_d;
	res_t                 res_q, res_d;

	logic [ALIGNED_W-1:0] al_c;
	logic [SIZE_W-1:0]    lim;
	logic                 spare_none;
	logic                 found;
	logic                 fit;
	logic                 grow_over;
	blk_t                 rd;

	assign rd = blk_rdata;
	assign lim = (heap_limit > SIZE_W'(HEAP_BYTES)) ? SIZE_W'(HEAP_BYTES) : heap_limit;
	assign spare_none = (fresh_q == LINK_W'(MAX_BLOCKS)) && (rec_q == '0);
	assign al_c = (state_q == S_IDLE) ?
		(({1'b0, req.request_size} + ALIGNED_W'(ALIGN_BYTES - 1)) &
		 ~ALIGNED_W'(ALIGN_BYTES - 1)) : al_q;
	assign found = ({1'b0, rd.start} + SIZE_W'(HEADER_BYTES)) == {1'b0, addr_q};
	assign fit = rd.free && ({1'b0, rd.size} >= al_q);
	assign grow_over = ({2'b0, brk_q} + 19'(HEADER_BYTES) + {1'b0, al_c}) > {2'b0, lim};
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= NO_SLOT;
			tail_q  <= NO_SLOT;
			brk_q   <= '0;
			fresh_q <= '0;
			rec_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			brk_q   <= brk_d;
			fresh_q <= fresh_d;
			rec_q   <= rec_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q        <= op_d;
		addr_q      <= addr_d;
		al_q        <= al_d;
		cur_q       <= cur_d;
		cur_rec_q   <= cur_rec_d;
		s_slot_q    <= s_slot_d;
		s_rec_q     <= s_rec_d;
		n_q         <= n_d;
		ctx_q       <= ctx_d;
		base_slot_q <= base_slot_d;
		base_rec_q  <= base_rec_d;
		res_q       <= res_d;
	end

	always_comb begin
		blk_t nb;
		nb = base_rec_q;
		state_d = state_q;
		head_d = head_q;
		tail_d = tail_q;
		brk_d = brk_q;
		fresh_d = fresh_q;
		rec_d = rec_q;
		op_d = op_q;
		addr_d = addr_q;
		al_d = al_q;
		cur_d = cur_q;
		cur_rec_d = cur_rec_q;
		s_slot_d = s_slot_q;
		s_rec_d = s_rec_q;
		n_d = n_q;
		ctx_d = ctx_q;
		base_slot_d = base_slot_q;
		base_rec_d = base_rec_q;
		res_d = res_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		blk_we = 1'b0;
		blk_waddr = cur_q[SLOT_W-1:0];
		blk_wdata = cur_rec_q;
		blk_raddr = head_q[SLOT_W-1:0];
		sp_we = 1'b0;
		sp_waddr = rec_q[SLOT_W-1:0];
		sp_wdata = base_rec_q.next[SLOT_W-1:0];
		sp_raddr = 8'(rec_q - 9'd1);

		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					op_d = req.opcode;
					addr_d = req.block_address;
					al_d = al_c;
					res_d = '0;
					case (req.opcode)
						OP_ALLOC: begin
							if (req.request_size == '0) begin
								res_d.status = ST_ZERO_SIZE;
								state_d = S_DONE;
							end else if (head_q[LINK_W-1]) begin
								if (grow_over) begin
									res_d.status = ST_EXHAUSTED;
									state_d = S_DONE;
								end else if (spare_none) begin
									res_d.status = ST_TABLE_FULL;
									state_d = S_DONE;
								end else begin
									ctx_d = TK_GROW;
									state_d = S_TAKE;
								end
							end else begin
								cur_d = head_q;
								state_d = S_ALLOC;
							end
						end
						OP_FREE, OP_REALLOC: begin
							if (req.opcode == OP_REALLOC && req.request_size == '0) begin
								res_d.status = ST_ZERO_SIZE;
								state_d = S_DONE;
							end else if (head_q[LINK_W-1]) begin
								res_d.status = ST_BAD_ADDR;
								state_d = S_DONE;
							end else begin
								cur_d = head_q;
								state_d = S_FIND;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_FIND: begin
				if (found) begin
					if (op_q == OP_FREE) begin
						base_slot_d = cur_q[SLOT_W-1:0];
						base_rec_d = rd;
						base_rec_d.free = 1'b1;
						state_d = S_MG_NX;
					end else begin
						s_slot_d = cur_q[SLOT_W-1:0];
						s_rec_d = rd;
						if ({1'b0, rd.size} >= al_q) begin
							if ({2'b0, rd.size} >= {1'b0, al_q} +
								19'(HEADER_BYTES + ALIGN_BYTES)) begin
								if (spare_none) begin
									res_d.status = ST_TABLE_FULL;
									state_d = S_DONE;
								end else begin
									ctx_d = TK_SHRINK;
									state_d = S_TAKE;
								end
							end else begin
								res_d.result_address = addr_q;
								res_d.old_size = rd.size;
								state_d = S_DONE;
							end
						end else if (head_q[LINK_W-1]) begin
							state_d = S_DONE;
						end else begin
							cur_d = head_q;
							state_d = S_ALLOC;
						end
					end
				end else if (rd.next[LINK_W-1]) begin
					res_d.status = ST_BAD_ADDR;
					state_d = S_DONE;
				end else begin
					blk_raddr = rd.next[SLOT_W-1:0];
					cur_d = rd.next;
				end
			end
			S_ALLOC: begin
				cur_rec_d = rd;
				if (fit) begin
					if ({2'b0, rd.size} > {1'b0, al_q} + 19'(HEADER_BYTES)) begin
						if (spare_none) begin
							res_d.status = ST_TABLE_FULL;
							state_d = S_DONE;
						end else begin
							ctx_d = TK_SPLIT;
							state_d = S_TAKE;
						end
					end else begin
						blk_we = 1'b1;
						blk_wdata = rd;
						blk_wdata.free = 1'b0;
						res_d.result_address = 16'(rd.start + 16'(HEADER_BYTES));
						if (op_q == OP_REALLOC) begin
							res_d.moved = 1'b1;
							res_d.old_size = s_rec_q.size;
							state_d = S_MG_LD;
						end else begin
							state_d = S_DONE;
						end
					end
				end else if (rd.next[LINK_W-1]) begin
					if (grow_over) begin
						res_d.status = ST_EXHAUSTED;
						state_d = S_DONE;
					end else if (spare_none) begin
						res_d.status = ST_TABLE_FULL;
						state_d = S_DONE;
					end else begin
						ctx_d = TK_GROW;
						state_d = S_TAKE;
					end
				end else begin
					blk_raddr = rd.next[SLOT_W-1:0];
					cur_d = rd.next;
				end
			end
			S_TAKE, S_TAKE_W: begin
				if (state_q == S_TAKE && rec_q != '0) begin
					rec_d = rec_q - 9'd1;
					state_d = S_TAKE_W;
				end else begin
					if (state_q == S_TAKE) begin
						n_d = fresh_q[SLOT_W-1:0];
						fresh_d = fresh_q + 9'd1;
					end else begin
						n_d = sp_rdata;
					end
					case (ctx_q)
						TK_SPLIT:  state_d = S_SPLIT;
						TK_GROW:   state_d = S_GROW;
						TK_SHRINK: state_d = S_SHRINK;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_SPLIT: begin
				blk_we = 1'b1;
				blk_waddr = n_q;
				blk_wdata.start = 16'(cur_rec_q.start + 16'(HEADER_BYTES) + al_q[15:0]);
				blk_wdata.size = 17'({1'b0, cur_rec_q.size} - al_q - 18'(HEADER_BYTES));
				blk_wdata.free = 1'b1;
				blk_wdata.next = cur_rec_q.next;
				state_d = S_SPLIT2;
			end
			S_SPLIT2: begin
				blk_we = 1'b1;
				blk_wdata.size = al_q[SIZE_W-1:0];
				blk_wdata.free = 1'b0;
				blk_wdata.next = {1'b0, n_q};
				if (tail_q == cur_q) begin
					tail_d = {1'b0, n_q};
				end
				res_d.result_address = 16'(cur_rec_q.start + 16'(HEADER_BYTES));
				if (op_q == OP_REALLOC) begin
					res_d.moved = 1'b1;
					res_d.old_size = s_rec_q.size;
					state_d = S_MG_LD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_GROW: begin
				blk_we = 1'b1;
				blk_waddr = n_q;
				blk_wdata.start = brk_q[START_W-1:0];
				blk_wdata.size = al_q[SIZE_W-1:0];
				blk_wdata.free = 1'b0;
				blk_wdata.next = NO_SLOT;
				res_d.result_address = 16'(brk_q + 17'(HEADER_BYTES));
				brk_d = 17'({2'b0, brk_q} + 19'(HEADER_BYTES) + {1'b0, al_q});
				tail_d = {1'b0, n_q};
				if (tail_q[LINK_W-1]) begin
					head_d = {1'b0, n_q};
					if (op_q == OP_REALLOC) begin
						res_d.moved = 1'b1;
						res_d.old_size = s_rec_q.size;
						state_d = S_MG_LD;
					end else begin
						state_d = S_DONE;
					end
				end else begin
					state_d = S_GROW2;
				end
			end
			S_GROW2: begin
				blk_we = 1'b1;
				blk_wdata.next = {1'b0, n_q};
				if (op_q == OP_REALLOC) begin
					res_d.moved = 1'b1;
					res_d.old_size = s_rec_q.size;
					state_d = S_MG_LD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SHRINK: begin
				blk_we = 1'b1;
				blk_waddr = s_slot_q;
				blk_wdata = s_rec_q;
				blk_wdata.size = al_q[SIZE_W-1:0];
				blk_wdata.next = {1'b0, n_q};
				if (tail_q == {1'b0, s_slot_q}) begin
					tail_d = {1'b0, n_q};
				end
				base_slot_d = n_q;
				base_rec_d.start = 16'(s_rec_q.start + 16'(HEADER_BYTES) + al_q[15:0]);
				base_rec_d.size = 17'({1'b0, s_rec_q.size} - al_q - 18'(HEADER_BYTES));
				base_rec_d.free = 1'b1;
				base_rec_d.next = s_rec_q.next;
				res_d.result_address = addr_q;
				res_d.old_size = s_rec_q.size;
				state_d = S_MG_NX;
			end
			S_MG_LD: begin
				blk_raddr = s_slot_q;
				state_d = S_MG_LDW;
			end
			S_MG_LDW: begin
				base_slot_d = s_slot_q;
				base_rec_d = rd;
				base_rec_d.free = 1'b1;
				state_d = S_MG_NX;
			end
			S_MG_NX: begin
				if (base_rec_q.next[LINK_W-1]) begin
					blk_we = 1'b1;
					blk_waddr = base_slot_q;
					blk_wdata = base_rec_q;
					state_d = S_DONE;
				end else begin
					blk_raddr = base_rec_q.next[SLOT_W-1:0];
					state_d = S_MG_EV;
				end
			end
			S_MG_EV: begin
				if (rd.free) begin
					nb.size = 17'(base_rec_q.size + 17'(HEADER_BYTES) + rd.size);
					nb.next = rd.next;
					base_rec_d = nb;
					if (tail_q == base_rec_q.next) begin
						tail_d = {1'b0, base_slot_q};
					end
					sp_we = 1'b1;
					rec_d = rec_q + 9'd1;
					if (rd.next[LINK_W-1]) begin
						blk_we = 1'b1;
						blk_waddr = base_slot_q;
						blk_wdata = nb;
						state_d = S_DONE;
					end else begin
						blk_raddr = rd.next[SLOT_W-1:0];
					end
				end else begin
					blk_we = 1'b1;
					blk_waddr = base_slot_q;
					blk_wdata = base_rec_q;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

[src/first_fit_heap_allocator.sv]
`timescale 1ns / 1ps
// First-fit heap allocator with forward coalescing.
// Requests enter on s_*: opcode allocate, free or reallocate, a size and a
// payload address. One response per request leaves on m_*: status, granted
// address, moved flag and old block size for an external copy engine.
// cfg_wen/cfg_wdata set heap_limit, the highest break offset; write only
// while no request is in flight.
// One request is worked at a time. Each list walk reads one block header at a
// time; an allocation that splits or grows then takes a spare slot and writes
// the headers. A free, or the remainder of a shrinking reallocate, then merges
// each following free block until the run ends on a used block or the list end.
// A reallocate that moves walks the list twice and rereads the old block
// before merging it. The walk rate is set by the single read port of
// the block table.
// A finished response sits in an output register; the next request is taken
// while it waits, but its response is held until m_tready frees the register.
// Reset empties the list, zeroes the break and returns every slot to the
// spare pool; no clearing pass is needed, s_tready is high right away.
module first_fit_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // opcode[1:0], request_size[18:2], block_address[34:19]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // status[2:0], result_address[18:3], moved[19], old_size[36:20]
	input  logic        cfg_wen,
	input  logic [16:0] cfg_wdata
);
	import ffa_pkg::*;

	logic [16:0] heap_limit_q;
	logic        out_valid_q;
	res_t        out_q;
	req_t        req;
	res_t        res;
	logic        res_valid, res_ready;

	logic              blk_we;
	logic [SLOT_W-1:0] blk_waddr, blk_raddr;
	blk_t              blk_wdata, blk_rdata;
	logic              sp_we;
	logic [SLOT_W-1:0] sp_waddr, sp_wdata, sp_raddr, sp_rdata;

	assign req = s_tdata[$bits(req_t)-1:0];
	assign res_ready = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(40 - $bits(res_t)){1'b0}}, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= 17'(HEAP_BYTES);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				heap_limit_q <= cfg_wdata;
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	ffa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_tvalid),
		.req_ready  (s_tready),
		.req        (req),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.heap_limit (heap_limit_q),
		.blk_we     (blk_we),
		.blk_waddr  (blk_waddr),
		.blk_wdata  (blk_wdata),
		.blk_raddr  (blk_raddr),
		.blk_rdata  (blk_rdata),
		.sp_we      (sp_we),
		.sp_waddr   (sp_waddr),
		.sp_wdata   (sp_wdata),
		.sp_raddr   (sp_raddr),
		.sp_rdata   (sp_rdata)
	);

	ffa_ram #(.WIDTH(BLK_W), .DEPTH(MAX_BLOCKS)) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (blk_waddr),
		.wdata (blk_wdata),
		.raddr (blk_raddr),
		.rdata (blk_rdata)
	);

	ffa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_BLOCKS)) u_spare_ram (
		.clk   (clk),
		.we    (sp_we),
		.waddr (sp_waddr),
		.wdata (sp_wdata),
		.raddr (sp_raddr),
		.rdata (sp_rdata)
	);
endmodule
